// ----- design/ddfc_pkg.sv -----
// ----------------------------------------------------------------------------
// ddfc_pkg
// Types and constants shared by the differential drive frame controller.
// ----------------------------------------------------------------------------
package ddfc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int QUOT_BITS   = 16;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] STOP_BYTE  = 8'hFE;

    localparam logic [1:0] CFG_CLEARANCE   = 2'd0;
    localparam logic [1:0] CFG_SIDE_SCALE  = 2'd1;
    localparam logic [1:0] CFG_SIDE_OFFSET = 2'd2;
    localparam logic [1:0] CFG_FRONT_SCALE = 2'd3;

    // ceil(2^17 / 5): exact floor of sum / 5 for any sum below 43690
    localparam int          SMOOTH_SHIFT = 17;
    localparam logic [14:0] SMOOTH_RECIP = 15'd26215;

    // ceil(10000 * 2^17 / 126): exact floor of mag * 10000 / 126 for mag below 1024
    localparam int          MIX_SHIFT = 17;
    localparam logic [23:0] MIX_RECIP = 24'd10402540;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [9:0]  left_sample;
        logic [9:0]  right_sample;
        logic [9:0]  front_sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0] servo_compare;
        logic [15:0] left_compare;
        logic [15:0] right_compare;
        logic        left_reverse;
        logic        right_reverse;
        logic        autonomous_on;
        logic [15:0] left_distance;
        logic [15:0] right_distance;
        logic [15:0] front_distance;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_lane_ctl;

    // (3*old + 2*x) / 5 with a zero sample counted as one
    function automatic logic [SAMPLE_BITS-1:0] smooth_level(
        input logic [SAMPLE_BITS-1:0] old_lvl,
        input logic [SAMPLE_BITS-1:0] raw
    );
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS+2:0] sum;
        logic [2*SAMPLE_BITS+8:0] prod;
        x    = (raw == '0) ? SAMPLE_BITS'(1) : raw;
        sum  = (SAMPLE_BITS+3)'(3) * (SAMPLE_BITS+3)'(old_lvl)
             + (SAMPLE_BITS+3)'(2) * (SAMPLE_BITS+3)'(x);
        // divide by five through the scaled reciprocal
        prod = (2*SAMPLE_BITS+9)'(sum) * (2*SAMPLE_BITS+9)'(SMOOTH_RECIP);
        smooth_level = prod[SMOOTH_SHIFT +: SAMPLE_BITS];
    endfunction

endpackage

// ----- design/ddfc_div_lane.sv -----
// ----------------------------------------------------------------------------
// ddfc_div_lane
// One distance lane: radix-2 restoring divide of a 16 bit scale by a level.
// ----------------------------------------------------------------------------
module ddfc_div_lane
    import ddfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [QUOT_BITS-1:0]   i_scale,
    input  logic [SAMPLE_BITS-1:0] i_level,
    output logic                   o_done,
    output logic [QUOT_BITS-1:0]   o_quot
);

    logic [QUOT_BITS-1:0]   r_quot;
    logic [SAMPLE_BITS:0]   r_rem;
    logic [SAMPLE_BITS-1:0] r_div;
    logic [4:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [SAMPLE_BITS+1:0] n_trial;
    logic [SAMPLE_BITS:0]   n_shift;

    assign n_shift = {r_rem[SAMPLE_BITS-1:0], r_quot[QUOT_BITS-1]};
    assign n_trial = {1'b0, n_shift} - {2'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QUOT_BITS);
                r_quot <= i_scale;
                r_rem  <= '0;
                r_div  <= (i_level == '0) ? SAMPLE_BITS'(1) : i_level;
            end else if (r_busy) begin
                // shift one quotient bit in per cycle
                if (!n_trial[SAMPLE_BITS+1]) begin
                    r_rem <= n_trial[SAMPLE_BITS:0];
                    r_quot <= {r_quot[QUOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quot <= {r_quot[QUOT_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/ddfc_merge.sv -----
// ----------------------------------------------------------------------------
// ddfc_merge
// Combines the lane distances with the held bytes into drive outputs.
// ----------------------------------------------------------------------------
module ddfc_merge
    import ddfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [15:0]      i_ld,
    input  logic [15:0]      i_rd,
    input  logic [15:0]      i_fd,
    input  logic [7:0]       i_b0,
    input  logic [7:0]       i_b1,
    input  logic [7:0]       i_b2,
    input  logic [7:0]       i_b3,
    input  logic [7:0]       i_thresh,
    output t_out_item        o_item
);

    logic        manual;
    logic [8:0]  fc;
    logic [8:0]  rc;
    logic signed [10:0] lmix;
    logic signed [10:0] rmix;
    logic [9:0]  lmag;
    logic [9:0]  rmag;
    logic [33:0] lprod;
    logic [33:0] rprod;
    t_out_item   r_item;

    always_comb begin
        manual = (i_b3 == 8'd1);
        if (manual) begin
            fc = {i_b0, 1'b0};
            rc = {i_b1, 1'b0};
        end else if (i_fd > {8'd0, i_thresh}) begin
            fc = 9'd25;
            rc = (i_ld > i_rd) ? 9'd90 : (i_rd > i_ld) ? 9'd160 : 9'd126;
        end else begin
            fc = 9'd131;
            rc = (i_ld > i_rd) ? 9'd35 : (i_rd > i_ld) ? 9'd205 : 9'd126;
        end
        lmix  = $signed({2'b0, fc}) - $signed({2'b0, rc});
        rmix  = $signed({2'b0, fc}) + $signed({2'b0, rc}) - 11'sd253;
        lmag  = lmix[10] ? 10'(-lmix) : lmix[9:0];
        rmag  = rmix[10] ? 10'(-rmix) : rmix[9:0];
        // mag * 10000 / 126 as one reciprocal multiply
        lprod = 34'(lmag) * 34'(MIX_RECIP);
        rprod = 34'(rmag) * 34'(MIX_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.servo_compare  <= 16'd2000 - {5'd0, i_b2, 3'd0};
            r_item.left_compare   <= lprod[MIX_SHIFT +: 16];
            r_item.right_compare  <= rprod[MIX_SHIFT +: 16];
            r_item.left_reverse   <= lmix[10];
            r_item.right_reverse  <= rmix[10];
            r_item.autonomous_on  <= !manual;
            r_item.left_distance  <= i_ld;
            r_item.right_distance <= i_rd;
            r_item.front_distance <= i_fd;
        end
    end

    assign o_item = r_item;

endmodule

// ----- design/differential_drive_frame_controller.sv -----
// ----------------------------------------------------------------------------
// differential_drive_frame_controller
// Serial framer, sensor smoothing, three parallel divide lanes and drive mix.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_ready  | i_in  (t_in_item)
// out     | out | o_valid / i_ready  | o_out (t_out_item)
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A frame is smoothed once its stop byte is accepted, then runs in the divide
// lanes side by side (16 quotient bits, then done, when the merge register
// loads), and then raises o_valid. Reset is synchronous and clears the
// framer, levels, held bytes and configuration registers. A stalled result is
// held in the output register; the input holds off until it is taken.
module differential_drive_frame_controller
    import ddfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_SMOOTH, ST_DIV, ST_MERGE} t_state;

    t_state r_state;
    logic [2:0] r_pos;
    logic [7:0] r_bytes [4];
    logic [SAMPLE_BITS-1:0] r_lvl [3];
    logic [SAMPLE_BITS-1:0] r_smp [3];
    logic [7:0]  r_thresh, r_soff;
    logic [15:0] r_sscale, r_fscale;
    logic        r_out_valid;
    t_lane_ctl   lane_ctl;
    logic [2:0]  lane_done;
    logic [15:0] lane_q [3];
    t_out_item   merged;
    logic        accept_in, frame_ok;

    assign o_ready     = (r_state == ST_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign accept_in   = i_valid && o_ready;
    assign frame_ok    = (r_pos == 3'd5) && (i_in.rx_byte == STOP_BYTE);

    assign lane_ctl.start = (r_state == ST_SMOOTH);
    assign lane_ctl.busy  = (r_state == ST_DIV);
    assign lane_ctl.done  = lane_done[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= 8'd29;
            r_sscale    <= 16'd21543;
            r_soff      <= 8'd26;
            r_fscale    <= 16'd6000;
            for (int i = 0; i < 4; i++) r_bytes[i] <= '0;
            for (int i = 0; i < 3; i++) r_lvl[i] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLEARANCE:   r_thresh <= i_cfg_data[7:0];
                    CFG_SIDE_SCALE:  r_sscale <= i_cfg_data;
                    CFG_SIDE_OFFSET: r_soff   <= i_cfg_data[7:0];
                    CFG_FRONT_SCALE: r_fscale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept_in) begin
                        if (r_pos >= 3'd1 && r_pos <= 3'd4) begin
                            r_bytes[2'(r_pos - 3'd1)] <= i_in.rx_byte;
                            r_pos <= r_pos + 3'd1;
                        end else begin
                            r_pos <= 3'd0;
                        end
                        if (i_in.rx_byte == START_BYTE) r_pos <= 3'd1;
                        if (frame_ok) begin
                            r_smp[0] <= i_in.left_sample;
                            r_smp[1] <= i_in.right_sample;
                            r_smp[2] <= i_in.front_sample;
                            r_state  <= ST_SMOOTH;
                        end
                    end
                end
                ST_SMOOTH: begin
                    // levels update here; lanes start from next-level values
                    for (int i = 0; i < 3; i++)
                        r_lvl[i] <= smooth_level(r_lvl[i], r_smp[i]);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (lane_ctl.done) r_state <= ST_MERGE;
                end
                ST_MERGE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic [SAMPLE_BITS-1:0] new_lvl [3];
    always_comb begin
        for (int i = 0; i < 3; i++) new_lvl[i] = smooth_level(r_lvl[i], r_smp[i]);
    end

    ddfc_div_lane u_lane_l (.i_clk, .i_rst_n, .i_start(lane_ctl.start),
        .i_scale(r_sscale), .i_level(new_lvl[0]), .o_done(lane_done[0]),
        .o_quot(lane_q[0]));
    ddfc_div_lane u_lane_r (.i_clk, .i_rst_n, .i_start(lane_ctl.start),
        .i_scale(r_sscale), .i_level(new_lvl[1]), .o_done(lane_done[1]),
        .o_quot(lane_q[1]));
    ddfc_div_lane u_lane_f (.i_clk, .i_rst_n, .i_start(lane_ctl.start),
        .i_scale(r_fscale), .i_level(new_lvl[2]), .o_done(lane_done[2]),
        .o_quot(lane_q[2]));

    ddfc_merge u_merge (
        .i_clk,
        .i_load   (lane_ctl.busy && lane_ctl.done && lane_done[1] && lane_done[2]),
        .i_ld     (lane_q[0] + {8'd0, r_soff}),
        .i_rd     (lane_q[1] + {8'd0, r_soff}),
        .i_fd     (lane_q[2]),
        .i_b0     (r_bytes[0]),
        .i_b1     (r_bytes[1]),
        .i_b2     (r_bytes[2]),
        .i_b3     (r_bytes[3]),
        .i_thresh (r_thresh),
        .o_item   (merged)
    );

    assign o_valid = r_out_valid;
    assign o_out   = merged;

endmodule
